// ----- sv/ovle_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovle_pkg
// shared types and constants of the ordered value list engine
// ----------------------------------------------------------------------------
package ovle_pkg;

  localparam int unsigned CapacityDef = 64;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned CountOutW   = 7;

  localparam logic [1:0] KindInsert = 2'd0;
  localparam logic [1:0] KindRemove = 2'd1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [ValueW-1:0] item_value;
  } in_beat_t;

  typedef struct packed {
    status_e                status;
    logic [CountOutW-1:0]   entry_count;
  } out_beat_t;

  typedef struct packed {
    logic      valid;
    out_beat_t beat;
  } resp_t;

endpackage

// ----- sv/ovle_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovle_mem
// value store, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module ovle_mem import ovle_pkg::*; #(
  parameter int unsigned CAPACITY = CapacityDef,
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [ValueW-1:0] wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [ValueW-1:0] rdata_o
);

  logic [ValueW-1:0] mem [CAPACITY];
  logic [ValueW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/ovle_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovle_ctrl
// sequencer: tail append, linear scan, shift down after a remove
// ----------------------------------------------------------------------------
module ovle_ctrl import ovle_pkg::*; #(
  parameter int unsigned CAPACITY = CapacityDef,
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_beat_t          in_i,
  input  logic              resp_ready_i,
  output resp_t             resp_o,
  output logic [CW-1:0]     count_o,
  output logic              mem_we_o,
  output logic [AW-1:0]     mem_waddr_o,
  output logic [ValueW-1:0] mem_wdata_o,
  output logic [AW-1:0]     mem_raddr_o,
  input  logic [ValueW-1:0] mem_rdata_i
);

  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     idx_q, idx_d;
  status_e           status_q, status_d;
  logic [1:0]        kind_q, kind_d;
  logic [ValueW-1:0] val_q, val_d;
  logic [CW-1:0]     idx_p1, idx_p2;
  logic              hit;

  assign idx_p1 = idx_q + CW'(1);
  assign idx_p2 = idx_q + CW'(2);
  assign hit    = (mem_rdata_i == val_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      idx_q    <= '0;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    val_q  <= val_d;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    status_d    = status_q;
    kind_d      = kind_q;
    val_d       = val_q;
    in_ready_o  = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q[AW-1:0];
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = idx_p1[AW-1:0];
    resp_o.valid            = 1'b0;
    resp_o.beat.status      = status_q;
    resp_o.beat.entry_count = CountOutW'(count_q);

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          kind_d = in_i.kind;
          val_d  = in_i.item_value;
          priority if (in_i.kind == KindInsert) begin
            state_d = S_RESP;
            if (count_q == CapCount) begin
              status_d = ST_FULL;
            end else begin
              mem_we_o    = 1'b1;
              mem_waddr_o = count_q[AW-1:0];
              mem_wdata_o = in_i.item_value;
              count_d     = count_q + CW'(1);
              status_d    = ST_OK;
            end
          end else if (count_q == '0) begin
            status_d = ST_MISSING;
            state_d  = S_RESP;
          end else begin
            mem_raddr_o = '0;
            idx_d       = '0;
            state_d     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          if (kind_q == KindRemove) begin
            if (idx_p1 == count_q) begin
              count_d  = count_q - CW'(1);
              status_d = ST_OK;
              state_d  = S_RESP;
            end else begin
              mem_raddr_o = idx_p1[AW-1:0];
              state_d     = S_SHIFT;
            end
          end else begin
            status_d = ST_OK;
            state_d  = S_RESP;
          end
        end else if (idx_p1 == count_q) begin
          status_d = ST_MISSING;
          state_d  = S_RESP;
        end else begin
          mem_raddr_o = idx_p1[AW-1:0];
          idx_d       = idx_p1;
        end
      end
      S_SHIFT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q[AW-1:0];
        mem_wdata_o = mem_rdata_i;
        if (idx_p2 == count_q) begin
          count_d  = count_q - CW'(1);
          status_d = ST_OK;
          state_d  = S_RESP;
        end else begin
          mem_raddr_o = idx_p2[AW-1:0];
          idx_d       = idx_p1;
        end
      end
      S_RESP: begin
        resp_o.valid = 1'b1;
        if (resp_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign count_o = count_q;

endmodule

// ----- sv/ordered_value_list_engine_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_value_list_engine_top
// ordered list of signed values kept in one synchronous memory
// insert appends at the tail; search and remove walk the list through the single read port
// a new beat is taken only when idle, after the response to the last one is passed on
// remove scans to the match, then shifts the later entries down one a cycle
// reset: entry count clears to zero, store contents stay undefined until written
// ----------------------------------------------------------------------------
module ordered_value_list_engine_top import ovle_pkg::*; #(
  parameter int unsigned CAPACITY = CapacityDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [ValueW-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [ValueW-1:0] mem_rdata;
  resp_t             resp;
  logic              resp_ready;
  logic [CW-1:0]     count;
  logic              out_valid_q, out_valid_d;
  out_beat_t         out_q, out_d;

  ovle_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_i         (in_i),
    .resp_ready_i (resp_ready),
    .resp_o       (resp),
    .count_o      (count),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  ovle_mem #(.CAPACITY(CAPACITY)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register
  assign resp_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (resp_ready) begin
      out_valid_d = resp.valid;
      out_d       = resp.beat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_full_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (resp.valid && resp.beat.status == ST_FULL) |-> count == CW'(CAPACITY))
    else $error("full status with free space");

  a_no_accept_while_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && resp.valid))
    else $error("input ready while a response is pending");

  a_insert_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_i.kind == KindInsert && count != CW'(CAPACITY))
    |=> count == $past(count) + CW'(1))
    else $error("insert did not grow the list");

endmodule
